// File: rtl/djtt_pkg.sv
// ----------------------------------------------------------------------------
// djtt_pkg
// Shared codes for the delayed job timer table: operations, result kinds and
// the empty-table marker.
// ----------------------------------------------------------------------------
package djtt_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

endpackage

// File: rtl/djtt_ram.sv
// ----------------------------------------------------------------------------
// djtt_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module djtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/delay_job_timer_table.sv
// ----------------------------------------------------------------------------
// delay_job_timer_table
// Table of delayed jobs (key, interval, last-armed time) held in one RAM,
// with per-slot valid flops. Add, delete, check and tick each scan the slots.
// ----------------------------------------------------------------------------
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+--------------------
//  input   | operation, job_key, interval, now         | in_valid & in_ready
//  output  | kind, out_key, present, status, min_left, | out_valid & out_ready
//          | last                                      |
//
//  Every operation reads each of the ENTRIES slots in turn through the one RAM
//  read port before the final result.
//  A tick holds its scan for every cycle in which an expired result finds the
//  output register full and unread; the final result waits the same way.
//  Reset clears the valid flops at once; no clearing pass.
//  A new input is taken once the final result is in the output register.
// ----------------------------------------------------------------------------
module delay_job_timer_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] job_key,
  input  logic [31:0] interval,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] out_key,
  output logic        present,
  output logic        status,
  output logic [31:0] min_left,
  output logic        last
);
  import djtt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] ival;
    logic [31:0] armed;
  } entry_t;

  state_t              state;
  logic [1:0]          op_q;
  logic [15:0]         key_q;
  logic [31:0]         ival_q;
  logic [31:0]         now_q;
  logic [CW-1:0]       cnt;
  logic                e_vld;
  logic [IW-1:0]       e_idx;
  logic [ENTRIES-1:0]  slot_valid;
  logic                hit;
  logic [IW-1:0]       hit_idx;
  logic                free_f;
  logic [IW-1:0]       free_idx;
  logic [31:0]         best;

  entry_t              rd_data;
  entry_t              wr_data;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic                we;

  logic                out_free;
  logic                out_load;
  logic                is_tick;
  logic                scan_more;
  logic                sv;
  logic [31:0]         age;
  logic [31:0]         left;
  logic                expired;
  logic                stall;
  logic                adv;

  always_comb begin
    out_free  = !out_valid || out_ready;
    is_tick   = (op_q == OP_TICK);
    scan_more = (cnt < CW'(ENTRIES));
    sv        = slot_valid[e_idx];
    age       = now_q - rd_data.armed;
    left      = rd_data.ival + rd_data.armed - now_q;
    expired   = sv && (age >= rd_data.ival);
    stall     = (state == ST_SCAN) && e_vld && is_tick && expired && !out_free;
    adv       = !stall;
    out_load  = ((state == ST_SCAN) && e_vld && is_tick && expired && out_free)
                || ((state == ST_FIN) && out_free);
    rd_addr   = (adv && scan_more) ? cnt[IW-1:0] : e_idx;
    we        = (state == ST_FIN) && out_free && (op_q == OP_ADD) && (hit || free_f);
    wr_addr   = hit ? hit_idx : free_idx;
    wr_data   = '{key: key_q, ival: ival_q, armed: now_q};
  end

  assign in_ready = (state == ST_IDLE);

  djtt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES),
    .AW   (IW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      slot_valid <= '0;
      e_vld      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q   <= operation;
            key_q  <= job_key;
            ival_q <= interval;
            now_q  <= now;
            cnt    <= '0;
            e_vld  <= 1'b0;
            hit    <= 1'b0;
            free_f <= 1'b0;
            best   <= ALL_ONES;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (adv) begin
            e_vld <= scan_more;
            if (scan_more) begin
              e_idx <= cnt[IW-1:0];
              cnt   <= cnt + CW'(1);
            end
            if (e_vld) begin
              if (is_tick) begin
                if (expired) begin
                  slot_valid[e_idx] <= 1'b0;
                  kind      <= KIND_EXPIRED;
                  out_key   <= rd_data.key;
                  present   <= 1'b0;
                  status    <= 1'b0;
                  min_left  <= '0;
                  last      <= 1'b0;
                end else if (sv && (left < best)) begin
                  best <= left;
                end
              end else begin
                if (sv && (rd_data.key == key_q) && !hit) begin
                  hit     <= 1'b1;
                  hit_idx <= e_idx;
                end
                if (!sv && !free_f) begin
                  free_f   <= 1'b1;
                  free_idx <= e_idx;
                end
              end
            end
            if (!scan_more && !e_vld) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            last     <= 1'b1;
            status   <= (op_q == OP_ADD) && !hit && !free_f;
            min_left <= is_tick ? best : '0;
            present  <= hit && !is_tick;
            out_key  <= is_tick ? '0 : key_q;
            kind     <= is_tick ? KIND_SUMMARY : KIND_ACK;
            case (op_q)
              OP_ADD: begin
                if (!hit && free_f) begin
                  slot_valid[free_idx] <= 1'b1;
                end
              end
              OP_DELETE: begin
                if (hit) begin
                  slot_valid[hit_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/djtt_checker.sv
// ----------------------------------------------------------------------------
// djtt_checker
// Port-level checks for the delayed job timer table, bound to the top level.
// ----------------------------------------------------------------------------
module djtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] out_key,
  input logic        present,
  input logic        status,
  input logic [31:0] min_left,
  input logic        last
);
  import djtt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_key)
      && $stable(present) && $stable(status) && $stable(min_left) && $stable(last))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an operation is in progress");

  a_expired_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EXPIRED) |-> !last && !present && !status
      && (min_left == '0))
    else $error("malformed expired result");

  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SUMMARY) |-> last && (out_key == '0) && !present
      && !status)
    else $error("malformed tick summary");

  a_full_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (kind == KIND_ACK) && !present && last)
    else $error("full status on a result other than an add acknowledge");

endmodule

bind delay_job_timer_table djtt_checker u_djtt_checker (.*);
